>>> rtl/gb3_pkg.sv
// Shared constants, codes and types of the 3x3 Gaussian blur stream.
package gb3_pkg;

    localparam int GB3_LINE_MAX = 4096;
    localparam int PIX_W        = 8;
    localparam int GEO_W        = 13;
    localparam int WEIGHT_W     = 16;
    localparam int ROWS_MAX     = 4096;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Row slots per line-memory word; a row lands in slot (row mod SLOTS).
    localparam int SLOTS  = 4;
    localparam int SLOT_W = 2;

    localparam logic [GEO_W-1:0]    RST_WIDTH   = 13'd640;
    localparam logic [GEO_W-1:0]    RST_HEIGHT  = 13'd480;
    localparam logic [WEIGHT_W-1:0] RST_CENTER  = 16'd13383;
    localparam logic [WEIGHT_W-1:0] RST_EDGE    = 16'd8113;
    localparam logic [WEIGHT_W-1:0] RST_CORNER  = 16'd4922;

    // Kernel group sums: four taps of eight bits each.
    localparam int GSUM_W = PIX_W + 2;
    localparam int PROD_W = WEIGHT_W + GSUM_W;
    localparam int ACC_W  = PROD_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_WEIGHT_CENTER = 3'd2,
        REG_WEIGHT_EDGE   = 3'd3,
        REG_WEIGHT_CORNER = 3'd4
    } gb3_reg_t;

    typedef enum logic {
        FUNC_PUSH  = 1'b0,
        FUNC_FLUSH = 1'b1
    } gb3_func_t;

    typedef enum logic [1:0] {
        COL_FIRST = 2'd0,
        COL_MID   = 2'd1,
        COL_LAST  = 2'd2
    } gb3_colpos_t;

    // One window column: rows above, at and below the output row.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } gb3_col_t;

endpackage

>>> rtl/gb3_stream_if.sv
// Valid/ready channel interfaces for the pixel input and result streams.
interface gb3_pix_in_if import gb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output func, output pixel_in, input ready);
    modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface gb3_pix_out_if import gb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;

    modport source (output valid, output pixel_out, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

>>> rtl/gaussian_blur_3x3_stream.sv
// Streaming 3x3 Gaussian blur: one line memory of row slots, a column window, MAC pipeline.
// Throughput: one beat per cycle unless the output stalls; the line memory does one column read
// and one write a cycle. A result passes stage 1, stage 2, stage 3 and the output register.
// A pixel's result is caused by the push that arrives one row and one pixel later; flush
// beats push out the last row and one pixel of a frame.
// Reset: counters and window clear, registers take their defaults; line memory is not cleared.
module gaussian_blur_3x3_stream import gb3_pkg::*; #(
    parameter int LINE_MAX = GB3_LINE_MAX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gb3_pix_in_if.sink            src,
    gb3_pix_out_if.source         dst,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(LINE_MAX);
    localparam int W_W    = $clog2(LINE_MAX + 1);
    localparam int LEAD_W = $clog2(LINE_MAX + 2);
    localparam int CMP_W  = (W_W > GEO_W) ? W_W : GEO_W;
    localparam int ROW_W  = GEO_W - 1;

    // Configuration registers
    logic [GEO_W-1:0]    width_reg, height_reg;
    logic [WEIGHT_W-1:0] wcenter_reg, wedge_reg, wcorner_reg;

    // Frame counters
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [GEO_W-1:0]  in_row_reg, in_row_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;

    // Line memory: each word holds one column of four row slots
    logic [SLOTS-1:0][PIX_W-1:0] line_mem [LINE_MAX];
    logic [SLOTS-1:0][PIX_W-1:0] rd_reg;

    // Pipeline
    logic              s1_valid_reg, s1_emit_reg, s1_last_reg, s1_push_reg, s1_tfb_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [SLOT_W-1:0] s1_mid_lane_reg, s1_top_lane_reg;
    gb3_colpos_t       s1_pos_reg;
    gb3_col_t          cola_reg, colb_reg;

    logic              s2_valid_reg, s2_last_reg;
    logic [GSUM_W-1:0] csum_reg, esum_reg;
    logic [PIX_W-1:0]  ctr_reg;

    logic              s3_valid_reg, s3_last_reg;
    logic [PROD_W-1:0] pcorner_reg, pedge_reg;
    logic [WEIGHT_W+PIX_W-1:0] pcenter_reg;

    logic              out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    // Effective geometry
    logic [CMP_W-1:0] width_ext;
    logic [W_W-1:0]   eff_w;
    logic [COL_W-1:0] wm1;
    logic [GEO_W-1:0] eff_h, hm1;
    logic [LEAD_W-1:0] lead_full;

    always_comb
    begin
        width_ext = CMP_W'(width_reg);
        if (width_ext < CMP_W'(2))
            eff_w = W_W'(2);
        else if (width_ext > CMP_W'(LINE_MAX))
            eff_w = W_W'(LINE_MAX);
        else
            eff_w = W_W'(width_ext);

        if (height_reg < GEO_W'(2))
            eff_h = GEO_W'(2);
        else if (height_reg > GEO_W'(ROWS_MAX))
            eff_h = GEO_W'(ROWS_MAX);
        else
            eff_h = height_reg;

        wm1       = COL_W'(eff_w - W_W'(1));
        hm1       = eff_h - GEO_W'(1);
        lead_full = LEAD_W'(eff_w) + LEAD_W'(1);
    end

    // Handshake chain
    logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, s2_load;
    logic accept;

    assign out_free = !out_valid_reg || dst.ready;
    assign s3_go    = s3_valid_reg && out_free;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_go    = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign s1_free  = !s1_valid_reg || s1_go;
    assign s2_load  = s1_go && s1_emit_reg;
    assign src.ready = s1_free;
    assign accept   = src.valid && s1_free;

    // Step decision for the accepted beat
    logic              done_in, is_push, emit_now, last_now, fetch_now, load_s1;
    logic [COL_W-1:0]  fetch_col;
    logic [SLOT_W-1:0] fetch_slot;
    gb3_colpos_t       pos_now;

    always_comb
    begin
        done_in   = in_row_reg >= eff_h;
        is_push   = (gb3_func_t'(src.func) == FUNC_PUSH) && !done_in;
        emit_now  = done_in || (is_push && lead_reg == lead_full);
        last_now  = emit_now && orow_reg == hm1[ROW_W-1:0] && ocol_reg == wm1;
        fetch_now = is_push || (done_in && !last_now);
        load_s1   = accept && (fetch_now || emit_now);

        // Past the last input row, fetch the next column of the final output row
        if (done_in)
        begin
            fetch_col  = (ocol_reg == wm1) ? '0 : ocol_reg + COL_W'(1);
            fetch_slot = eff_h[SLOT_W-1:0];
        end
        else
        begin
            fetch_col  = in_col_reg;
            fetch_slot = in_row_reg[SLOT_W-1:0];
        end

        if (ocol_reg == '0)
            pos_now = COL_FIRST;
        else if (ocol_reg == wm1)
            pos_now = COL_LAST;
        else
            pos_now = COL_MID;
    end

    // Counter update
    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;

        if (accept)
        begin
            if (last_now)
            begin
                in_col_next = '0;
                in_row_next = '0;
                lead_next   = '0;
                ocol_next   = '0;
                orow_next   = '0;
            end
            else
            begin
                if (is_push)
                begin
                    if (in_col_reg == wm1)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + GEO_W'(1);
                    end
                    else
                    begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                    if (!emit_now)
                        lead_next = lead_reg + LEAD_W'(1);
                end
                if (emit_now)
                begin
                    if (ocol_reg == wm1)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + COL_W'(1);
                    end
                end
            end
        end

        // A geometry write drops the frame in progress
        if (cfg_we && (gb3_reg_t'(cfg_index) == REG_IMAGE_WIDTH ||
                       gb3_reg_t'(cfg_index) == REG_IMAGE_HEIGHT))
        begin
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            ocol_next   = '0;
            orow_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            wcenter_reg <= RST_CENTER;
            wedge_reg   <= RST_EDGE;
            wcorner_reg <= RST_CORNER;
        end
        else if (cfg_we)
        begin
            case (gb3_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   width_reg   <= cfg_data[GEO_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg  <= cfg_data[GEO_W-1:0];
                REG_WEIGHT_CENTER: wcenter_reg <= cfg_data;
                REG_WEIGHT_EDGE:   wedge_reg   <= cfg_data;
                REG_WEIGHT_CORNER: wcorner_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            lead_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    // Line memory: write the pushed pixel into its row slot, read the fetched column
    always_ff @(posedge clk)
    begin
        if (accept && is_push)
            line_mem[in_col_reg][in_row_reg[SLOT_W-1:0]] <= src.pixel_in;
        if (accept && fetch_now)
            rd_reg <= line_mem[fetch_col];
    end

    // Stage 1 sideband
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load_s1)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_emit_reg     <= emit_now;
            s1_last_reg     <= last_now;
            s1_push_reg     <= is_push;
            s1_tfb_reg      <= is_push && in_row_reg == GEO_W'(1);
            s1_pix_reg      <= src.pixel_in;
            s1_mid_lane_reg <= fetch_slot - SLOT_W'(1);
            s1_top_lane_reg <= fetch_slot - SLOT_W'(2);
            s1_pos_reg      <= pos_now;
        end
    end

    // New column and window taps
    gb3_col_t         col_new, col_l, col_c, col_r;
    logic [PIX_W-1:0] top_raw;

    always_comb
    begin
        top_raw     = rd_reg[s1_top_lane_reg];
        col_new.mid = rd_reg[s1_mid_lane_reg];
        // Mirror at the bottom edge: the row below reads the row above
        col_new.bot = s1_push_reg ? s1_pix_reg : top_raw;
        // Mirror at the top edge: the row above reads the row below
        col_new.top = s1_tfb_reg ? col_new.bot : top_raw;

        case (s1_pos_reg)
            COL_FIRST:
            begin
                col_l = col_new;
                col_c = cola_reg;
                col_r = col_new;
            end
            COL_LAST:
            begin
                col_l = colb_reg;
                col_c = cola_reg;
                col_r = colb_reg;
            end
            default:
            begin
                col_l = colb_reg;
                col_c = cola_reg;
                col_r = col_new;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cola_reg <= '0;
            colb_reg <= '0;
        end
        else if (s1_go)
        begin
            cola_reg <= col_new;
            colb_reg <= cola_reg;
        end
    end

    // Stage 2: group sums per weight class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= 1'b1;
        else if (s2_go)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            csum_reg    <= GSUM_W'(col_l.top) + GSUM_W'(col_l.bot)
                         + GSUM_W'(col_r.top) + GSUM_W'(col_r.bot);
            esum_reg    <= GSUM_W'(col_c.top) + GSUM_W'(col_c.bot)
                         + GSUM_W'(col_l.mid) + GSUM_W'(col_r.mid);
            ctr_reg     <= col_c.mid;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: weight products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s2_go)
            s3_valid_reg <= 1'b1;
        else if (s3_go)
            s3_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            pcorner_reg <= PROD_W'(wcorner_reg) * PROD_W'(csum_reg);
            pedge_reg   <= PROD_W'(wedge_reg) * PROD_W'(esum_reg);
            pcenter_reg <= (WEIGHT_W+PIX_W)'(wcenter_reg) * (WEIGHT_W+PIX_W)'(ctr_reg);
            s3_last_reg <= s2_last_reg;
        end
    end

    // Output register: round half up, saturate
    logic [ACC_W-1:0]         acc;
    logic [ACC_W-WEIGHT_W-1:0] rounded;
    logic [PIX_W-1:0]         pix_sat;

    always_comb
    begin
        acc = ACC_W'(pcorner_reg) + ACC_W'(pedge_reg) + ACC_W'(pcenter_reg)
            + (ACC_W'(1) << (WEIGHT_W - 1));
        rounded = acc[ACC_W-1:WEIGHT_W];
        pix_sat = (|rounded[ACC_W-WEIGHT_W-1:PIX_W]) ? '1 : rounded[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_go)
            out_valid_reg <= 1'b1;
        else if (dst.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            out_pix_reg  <= pix_sat;
            out_last_reg <= s3_last_reg;
        end
    end

    assign dst.valid         = out_valid_reg;
    assign dst.pixel_out     = out_pix_reg;
    assign dst.last_of_frame = out_last_reg;

    // Checks
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= lead_full)
        else $error("pending output lead beyond one row plus one pixel");

    a_geo_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (gb3_reg_t'(cfg_index) == REG_IMAGE_WIDTH ||
                   gb3_reg_t'(cfg_index) == REG_IMAGE_HEIGHT)
        |=> in_row_reg == '0 && in_col_reg == '0 && orow_reg == '0 && lead_reg == '0)
        else $error("geometry write did not restart the frame");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_now |=> in_row_reg == '0 && ocol_reg == '0 && orow_reg == '0)
        else $error("frame end did not clear the counters");

    a_emit_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |-> s1_valid_reg && s1_emit_reg && s2_free)
        else $error("window stage handed on an item without a result");

endmodule
